### rtl/core/irrigation_climate_controller_core_macros.svh
// Assertion macros for the irrigation climate controller core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef IRRIGATION_CLIMATE_CONTROLLER_CORE_MACROS_SVH
`define IRRIGATION_CLIMATE_CONTROLLER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ICC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/icc_pkg.sv
// Shared types, codes and preset table of the irrigation climate controller.
// No dependencies.
package icc_pkg;

    localparam int SETTING_ITEMS = 5;
    localparam int PRESET_COUNT  = 3;
    localparam logic [6:0] SOIL_STEP_MAX = 7'd99;
    localparam logic [4:0] TEMP_LOW_MAX  = 5'd30;
    localparam logic [5:0] TEMP_HIGH_MIN = 6'd20;
    localparam logic [5:0] TEMP_HIGH_MAX = 6'd50;
    localparam logic [3:0] TICK_SAT      = 4'd15;

    typedef enum logic [1:0] {
        MODE_AUTO     = 2'd0,
        MODE_MANUAL   = 2'd1,
        MODE_SETTINGS = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_NORMAL = 2'd0,
        STAT_DRY    = 2'd1,
        STAT_COLD   = 2'd2,
        STAT_HOT    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        KEY1_SHORT = 3'd0,
        KEY1_LONG  = 3'd1,
        KEY2       = 3'd2,
        KEY3       = 3'd3,
        KEY4       = 3'd4
    } key_t;

    typedef enum logic [2:0] {
        LIM_PLANT   = 3'd0,
        LIM_SOIL_LO = 3'd1,
        LIM_SOIL_HI = 3'd2,
        LIM_TEMP_LO = 3'd3,
        LIM_TEMP_HI = 3'd4
    } limit_sel_t;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    localparam logic CFG_FAN_HYST   = 1'b0;
    localparam logic CFG_BEEP_TICKS = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [6:0]        soil_percent;
        logic signed [11:0] temperature;
        logic              temperature_valid;
        logic [2:0]        key_code;
    } in_item_t;

    typedef struct packed {
        logic       pump_drive;
        logic       fan_drive;
        logic       led_red;
        logic       green_lamp;
        logic       blue_lamp;
        logic       beeper;
        logic [1:0] run_mode;
        logic [1:0] plant_status;
        logic       alarm_flag;
        logic       mute_flag;
        logic [2:0] edit_position;
        logic [6:0] edit_value;
    } out_item_t;

    // Temperatures in whole degrees.
    typedef struct packed {
        logic [1:0] plant;
        logic [6:0] soil_lo;
        logic [6:0] soil_hi;
        logic [4:0] temp_lo;
        logic [5:0] temp_hi;
    } limits_t;

    typedef struct packed {
        logic    pump;
        logic    fan;
        status_t status;
        logic    alarm;
        logic    status_changed;
    } auto_res_t;

    typedef struct packed {
        mode_t      mode;
        status_t    status;
        logic       alarm;
        logic       muted;
        logic       red;
        logic       beep;
        logic [3:0] count;
        logic [3:0] ticks;
    } indic_in_t;

    typedef struct packed {
        logic       red;
        logic       green;
        logic       blue;
        logic       beep;
        logic [3:0] count;
    } indic_out_t;

    function automatic limits_t preset_limits(input logic [1:0] idx);
        limits_t l;
        unique case (idx)
            2'd0:    l = '{plant: 2'd0, soil_lo: 7'd20, soil_hi: 7'd40,
                           temp_lo: 5'd10, temp_hi: 6'd38};
            2'd2:    l = '{plant: 2'd2, soil_lo: 7'd50, soil_hi: 7'd80,
                           temp_lo: 5'd18, temp_hi: 6'd32};
            default: l = '{plant: 2'd1, soil_lo: 7'd30, soil_hi: 7'd60,
                           temp_lo: 5'd15, temp_hi: 6'd35};
        endcase
        return l;
    endfunction

    function automatic logic [6:0] limit_field(input limits_t l, input logic [2:0] sel);
        logic [6:0] v;
        unique case (sel)
            LIM_PLANT:   v = {5'd0, l.plant};
            LIM_SOIL_LO: v = l.soil_lo;
            LIM_SOIL_HI: v = l.soil_hi;
            LIM_TEMP_LO: v = {2'd0, l.temp_lo};
            LIM_TEMP_HI: v = {1'b0, l.temp_hi};
            default:     v = {5'd0, l.plant};
        endcase
        return v;
    endfunction

endpackage

### rtl/core/icc_auto.sv
// Auto-mode control: pump soil band, fan threshold with hysteresis, status and alarm.
// Depends on icc_pkg.
module icc_auto
    import icc_pkg::*;
(
    input  limits_t            limits,
    input  logic [7:0]         fan_hyst,
    input  logic [6:0]         soil,
    input  logic signed [11:0] temp,
    input  logic               temp_ok,
    input  logic               pump_cur,
    input  logic               fan_cur,
    input  status_t            status_cur,
    output auto_res_t          res
);

    logic signed [12:0] temp_ext;
    logic signed [12:0] hi_raw;
    logic signed [12:0] lo_raw;
    logic signed [12:0] fan_off_thr;
    logic               very_dry;
    logic               hot;
    logic               cold;
    logic               above_hi;

    assign temp_ext    = {temp[11], temp};
    assign hi_raw      = $signed({3'd0, limits.temp_hi, 4'd0});
    assign lo_raw      = $signed({4'd0, limits.temp_lo, 4'd0});
    assign fan_off_thr = hi_raw - $signed({5'd0, fan_hyst});
    assign above_hi    = temp_ext > hi_raw;
    assign very_dry    = soil < limits.soil_lo;
    assign hot         = temp_ok && above_hi;
    assign cold        = temp_ok && (temp_ext < lo_raw);

    always_comb
    begin
        res.pump = pump_cur;
        if (very_dry)
            res.pump = 1'b1;
        else if (soil >= limits.soil_hi)
            res.pump = 1'b0;

        res.fan = fan_cur;
        if (temp_ok)
        begin
            if (above_hi)
                res.fan = 1'b1;
            else if (temp_ext <= fan_off_thr)
                res.fan = 1'b0;
        end

        priority if (very_dry)
            res.status = STAT_DRY;
        else if (hot)
            res.status = STAT_HOT;
        else if (cold)
            res.status = STAT_COLD;
        else if (soil < limits.soil_hi)
            res.status = STAT_DRY;
        else
            res.status = STAT_NORMAL;

        res.status_changed = res.status != status_cur;
        res.alarm          = very_dry || hot;
    end

endmodule

### rtl/core/icc_edit.sv
// Settings edit step: bounded up/down on the selected limit, preset load on plant type.
// Depends on icc_pkg.
module icc_edit
    import icc_pkg::*;
(
    input  limits_t    cur,
    input  logic [2:0] sel,
    input  logic       step_en,
    input  logic       step_up,
    output limits_t    nxt
);

    localparam logic [1:0] PLANT_MAX = 2'(PRESET_COUNT - 1);

    always_comb
    begin
        nxt = cur;
        if (step_en)
        begin
            unique case (sel)
                LIM_PLANT:
                begin
                    if (step_up && cur.plant < PLANT_MAX)
                        nxt = preset_limits(cur.plant + 2'd1);
                    else if (!step_up && cur.plant != 2'd0)
                        nxt = preset_limits(cur.plant - 2'd1);
                end
                LIM_SOIL_LO:
                begin
                    if (step_up && cur.soil_lo <= SOIL_STEP_MAX)
                        nxt.soil_lo = cur.soil_lo + 7'd1;
                    else if (!step_up && cur.soil_lo != 7'd0)
                        nxt.soil_lo = cur.soil_lo - 7'd1;
                end
                LIM_SOIL_HI:
                begin
                    if (step_up && cur.soil_hi <= SOIL_STEP_MAX)
                        nxt.soil_hi = cur.soil_hi + 7'd1;
                    else if (!step_up && cur.soil_hi != 7'd0)
                        nxt.soil_hi = cur.soil_hi - 7'd1;
                end
                LIM_TEMP_LO:
                begin
                    if (step_up && cur.temp_lo < TEMP_LOW_MAX)
                        nxt.temp_lo = cur.temp_lo + 5'd1;
                    else if (!step_up && cur.temp_lo != 5'd0)
                        nxt.temp_lo = cur.temp_lo - 5'd1;
                end
                LIM_TEMP_HI:
                begin
                    if (step_up && cur.temp_hi < TEMP_HIGH_MAX)
                        nxt.temp_hi = cur.temp_hi + 6'd1;
                    else if (!step_up && cur.temp_hi > TEMP_HIGH_MIN)
                        nxt.temp_hi = cur.temp_hi - 6'd1;
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

### rtl/core/icc_indic.sv
// Sample-tick update of the three LEDs and the alarm beeper with its toggle counter.
// Depends on icc_pkg.
module icc_indic
    import icc_pkg::*;
(
    input  indic_in_t  ind_in,
    output indic_out_t ind_out
);

    logic [3:0] count_inc;

    assign count_inc = (ind_in.count < TICK_SAT) ? ind_in.count + 4'd1 : ind_in.count;

    always_comb
    begin
        ind_out.red   = 1'b0;
        ind_out.green = 1'b0;
        ind_out.blue  = 1'b0;
        if (ind_in.mode == MODE_SETTINGS)
            ind_out.blue = 1'b1;
        else
        begin
            unique case (ind_in.status)
                STAT_NORMAL: ind_out.green = 1'b1;
                STAT_DRY:    ind_out.red   = ind_in.alarm ? !ind_in.red : 1'b1;
                STAT_COLD:   ind_out.blue  = 1'b1;
                STAT_HOT:    ind_out.red   = !ind_in.red;
                default:     ind_out.green = 1'b1;
            endcase
        end

        // Silence when no alarm or muted; else toggle once the interval is reached.
        ind_out.count = count_inc;
        ind_out.beep  = ind_in.beep;
        if (!ind_in.alarm || ind_in.muted)
            ind_out.beep = 1'b0;
        else if (count_inc >= ind_in.ticks)
        begin
            ind_out.count = 4'd0;
            ind_out.beep  = !ind_in.beep;
        end
    end

endmodule

### rtl/core/irrigation_climate_controller_core.sv
// Irrigation climate controller core: top level with input, state and result registers.
// Depends on icc_pkg, icc_auto, icc_edit, icc_indic and the core macros header.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries sample ticks and key events.
//   Output channel out_valid/out_stall/out_data returns one result per request.
//   A request taken sits in the input register until the output register is free;
//   it then updates the controller state and its result is loaded into the output
//   register, where out_valid rises and the result waits until it is taken.
//   Throughput is one request per cycle unless the receiver stalls; the state
//   update is a single short combinational pass between the input register and
//   the state/result registers.
//   When the receiver stalls, the result holds in the output register; the input
//   register still takes one more request, then in_stall rises until the result
//   is taken.
//   cfg_write/cfg_index/cfg_data write fan_hysteresis (index 0) and
//   beep_toggle_ticks (index 1); write only while the block is idle.
//   Reset (rst_n low) empties both registers, loads the general preset into the
//   active and edit limits, selects auto mode and lights the green LED.
`include "irrigation_climate_controller_core_macros.svh"

module irrigation_climate_controller_core
    import icc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_write,
    input  logic      cfg_index,
    input  logic [7:0] cfg_data
);

    localparam logic [2:0] SEL_LAST = 3'(SETTING_ITEMS - 1);

    logic       in_valid_reg;
    in_item_t   in_data_reg;
    logic       out_valid_reg;
    out_item_t  out_data_reg;
    out_item_t  out_data_next;

    logic [7:0] fan_hyst_reg;
    logic [3:0] beep_ticks_reg;

    logic       pump_reg,   pump_next;
    logic       fan_reg,    fan_next;
    mode_t      mode_reg,   mode_next;
    status_t    status_reg, status_next;
    logic       alarm_reg,  alarm_next;
    logic       muted_reg,  muted_next;
    logic       red_reg,    red_next;
    logic       green_reg,  green_next;
    logic       blue_reg,   blue_next;
    logic       beep_reg,   beep_next;
    logic [3:0] count_reg,  count_next;
    logic [2:0] sel_reg,    sel_next;
    limits_t    active_reg, active_next;
    limits_t    edit_reg,   edit_next;

    logic       accept;
    logic       adv;
    logic       is_tick;
    logic       is_key;
    logic       in_auto;
    logic       step_en;
    auto_res_t  auto_res;
    limits_t    edit_stepped;
    indic_in_t  ind_in;
    indic_out_t ind_out;
    logic       tick_muted;
    logic       alarm_cause;
    logic       out_drain;

    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign adv       = in_valid_reg && !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_tick = in_data_reg.operation == OP_TICK;
    assign is_key  = in_data_reg.operation == OP_KEY;
    assign in_auto = mode_reg == MODE_AUTO;
    assign step_en = is_key && (mode_reg == MODE_SETTINGS)
                     && (in_data_reg.key_code == KEY2 || in_data_reg.key_code == KEY3);

    icc_auto u_auto (
        .limits     (active_reg),
        .fan_hyst   (fan_hyst_reg),
        .soil       (in_data_reg.soil_percent),
        .temp       (in_data_reg.temperature),
        .temp_ok    (in_data_reg.temperature_valid),
        .pump_cur   (pump_reg),
        .fan_cur    (fan_reg),
        .status_cur (status_reg),
        .res        (auto_res)
    );

    icc_edit u_edit (
        .cur     (edit_reg),
        .sel     (sel_reg),
        .step_en (step_en),
        .step_up (in_data_reg.key_code == KEY3),
        .nxt     (edit_stepped)
    );

    // Indicators see the status and alarm as left by the auto pass.
    assign tick_muted   = (in_auto && auto_res.status_changed) ? 1'b0 : muted_reg;
    assign ind_in.mode  = mode_reg;
    assign ind_in.status = in_auto ? auto_res.status : status_reg;
    assign ind_in.alarm = in_auto ? auto_res.alarm : alarm_reg;
    assign ind_in.muted = tick_muted;
    assign ind_in.red   = red_reg;
    assign ind_in.beep  = beep_reg;
    assign ind_in.count = count_reg;
    assign ind_in.ticks = beep_ticks_reg;

    icc_indic u_indic (
        .ind_in  (ind_in),
        .ind_out (ind_out)
    );

    always_comb
    begin
        pump_next   = pump_reg;
        fan_next    = fan_reg;
        mode_next   = mode_reg;
        status_next = status_reg;
        alarm_next  = alarm_reg;
        muted_next  = muted_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        beep_next   = beep_reg;
        count_next  = count_reg;
        sel_next    = sel_reg;
        active_next = active_reg;
        edit_next   = edit_stepped;

        if (is_tick)
        begin
            if (in_auto)
            begin
                pump_next   = auto_res.pump;
                fan_next    = auto_res.fan;
                status_next = auto_res.status;
                alarm_next  = auto_res.alarm;
                muted_next  = tick_muted;
            end
            red_next   = ind_out.red;
            green_next = ind_out.green;
            blue_next  = ind_out.blue;
            beep_next  = ind_out.beep;
            count_next = ind_out.count;
        end
        else if (mode_reg == MODE_SETTINGS)
        begin
            unique case (in_data_reg.key_code)
                KEY1_SHORT: sel_next = (sel_reg == SEL_LAST) ? 3'd0 : sel_reg + 3'd1;
                KEY4:
                begin
                    active_next = edit_reg;
                    mode_next   = MODE_AUTO;
                    muted_next  = 1'b0;
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (in_data_reg.key_code)
                KEY1_SHORT: mode_next = in_auto ? MODE_MANUAL : MODE_AUTO;
                KEY1_LONG:
                begin
                    edit_next = active_reg;
                    sel_next  = 3'd0;
                    mode_next = MODE_SETTINGS;
                end
                KEY2: if (mode_reg == MODE_MANUAL) pump_next = !pump_reg;
                KEY3: if (mode_reg == MODE_MANUAL) fan_next = !fan_reg;
                KEY4:
                begin
                    muted_next = !muted_reg;
                    if (!muted_reg)
                        beep_next = 1'b0;
                end
                default: ;
            endcase
        end

        out_data_next.pump_drive    = pump_next;
        out_data_next.fan_drive     = fan_next;
        out_data_next.led_red       = red_next;
        out_data_next.green_lamp    = green_next;
        out_data_next.blue_lamp     = blue_next;
        out_data_next.beeper        = beep_next;
        out_data_next.run_mode      = mode_next;
        out_data_next.plant_status  = status_next;
        out_data_next.alarm_flag    = alarm_next;
        out_data_next.mute_flag     = muted_next;
        out_data_next.edit_position = sel_next;
        out_data_next.edit_value    = limit_field(edit_next, sel_next);
    end

    // Handshake and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fan_hyst_reg   <= 8'd32;
            beep_ticks_reg <= 4'd3;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (adv)
                in_valid_reg <= 1'b0;

            if (adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_FAN_HYST:   fan_hyst_reg   <= cfg_data;
                    CFG_BEEP_TICKS: beep_ticks_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= in_data;
        if (adv)
            out_data_reg <= out_data_next;
    end

    // Controller state; advance once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_reg   <= 1'b0;
            fan_reg    <= 1'b0;
            mode_reg   <= MODE_AUTO;
            status_reg <= STAT_NORMAL;
            alarm_reg  <= 1'b0;
            muted_reg  <= 1'b0;
            red_reg    <= 1'b0;
            green_reg  <= 1'b1;
            blue_reg   <= 1'b0;
            beep_reg   <= 1'b0;
            count_reg  <= 4'd0;
            sel_reg    <= 3'd0;
            active_reg <= preset_limits(2'd1);
            edit_reg   <= preset_limits(2'd1);
        end
        else if (adv)
        begin
            pump_reg   <= pump_next;
            fan_reg    <= fan_next;
            mode_reg   <= mode_next;
            status_reg <= status_next;
            alarm_reg  <= alarm_next;
            muted_reg  <= muted_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            beep_reg   <= beep_next;
            count_reg  <= count_next;
            sel_reg    <= sel_next;
            active_reg <= active_next;
            edit_reg   <= edit_next;
        end
    end

    assign alarm_cause = status_reg == STAT_DRY || status_reg == STAT_HOT;
    assign out_drain   = out_valid_reg && !out_stall && !adv;

    `ICC_ASSERT_SAME(a_beep_needs_alarm, beep_reg, alarm_reg && !muted_reg, "beep without alarm")
    `ICC_ASSERT_SAME(a_alarm_status, alarm_reg, alarm_cause, "alarm with status not dry or hot")
    `ICC_ASSERT_SAME(a_sel_range, 1'b1, sel_reg <= SEL_LAST, "selected setting out of range")
    `ICC_ASSERT_NEXT(a_out_drains, out_drain, !out_valid_reg, "taken result not retired")

endmodule

### verif/icc_shadow_pkg.sv
// Shadow copy of the irrigation climate controller state: predicts the result of
// every accepted request and checks the block's results in order. Depends on icc_pkg.
package icc_shadow_pkg;

    import icc_pkg::*;

    localparam int GENERAL_PLANT = 1;

    class icc_shadow;

        logic [7:0] fan_hyst;
        logic [3:0] beep_ticks;

        logic       pump;
        logic       fan;
        logic       red;
        logic       green;
        logic       blue;
        logic       beep;
        logic       alarm;
        logic       muted;
        mode_t      mode;
        status_t    status;
        logic [3:0] tick_count;
        logic [2:0] position;
        logic [6:0] active_lim[SETTING_ITEMS];
        logic [6:0] edit_lim[SETTING_ITEMS];

        out_item_t  awaited[$];
        int         failures;

        function new();
            fan_hyst   = 8'd32;
            beep_ticks = 4'd3;
            pump       = 1'b0;
            fan        = 1'b0;
            red        = 1'b0;
            green      = 1'b1;
            blue       = 1'b0;
            beep       = 1'b0;
            alarm      = 1'b0;
            muted      = 1'b0;
            mode       = MODE_AUTO;
            status     = STAT_NORMAL;
            tick_count = 4'd0;
            position   = LIM_PLANT;
            failures   = 0;
            for (int n = 0; n < SETTING_ITEMS; n++)
            begin
                active_lim[n] = preset_entry(GENERAL_PLANT, n);
                edit_lim[n]   = active_lim[n];
            end
        endfunction

        function logic [6:0] preset_entry(int plant, int n);
            logic [6:0] row[SETTING_ITEMS];
            case (plant)
                0:       row = '{7'd0, 7'd20, 7'd40, 7'd10, 7'd38};
                2:       row = '{7'd2, 7'd50, 7'd80, 7'd18, 7'd32};
                default: row = '{7'd1, 7'd30, 7'd60, 7'd15, 7'd35};
            endcase
            return row[n];
        endfunction

        function void load_edit(int plant);
            for (int n = 0; n < SETTING_ITEMS; n++)
                edit_lim[n] = preset_entry(plant, n);
        endfunction

        function void run_auto(logic [6:0] soil, int temp, logic valid);
            status_t prior;
            int      lo_raw;
            int      hi_raw;
            logic    very_dry;
            logic    hot;
            logic    cold;
            prior    = status;
            lo_raw   = int'(active_lim[LIM_TEMP_LO]) * 16;
            hi_raw   = int'(active_lim[LIM_TEMP_HI]) * 16;
            very_dry = soil < active_lim[LIM_SOIL_LO];
            hot      = valid && (temp > hi_raw);
            cold     = valid && (temp < lo_raw);

            if (very_dry)
                pump = 1'b1;
            else if (soil >= active_lim[LIM_SOIL_HI])
                pump = 1'b0;

            // hold the fan on an invalid reading
            if (valid)
            begin
                if (temp > hi_raw)
                    fan = 1'b1;
                else if (temp <= hi_raw - int'(fan_hyst))
                    fan = 1'b0;
            end

            if (very_dry)
                status = STAT_DRY;
            else if (hot)
                status = STAT_HOT;
            else if (cold)
                status = STAT_COLD;
            else if (soil < active_lim[LIM_SOIL_HI])
                status = STAT_DRY;
            else
                status = STAT_NORMAL;

            if (status != prior)
                muted = 1'b0;
            alarm = very_dry || hot;
        endfunction

        function void refresh_lamps();
            if (mode == MODE_SETTINGS)
            begin
                green = 1'b0;
                red   = 1'b0;
                blue  = 1'b1;
            end
            else
            begin
                case (status)
                    STAT_NORMAL:
                    begin
                        green = 1'b1;
                        red   = 1'b0;
                        blue  = 1'b0;
                    end
                    STAT_DRY:
                    begin
                        green = 1'b0;
                        blue  = 1'b0;
                        red   = alarm ? ~red : 1'b1;
                    end
                    STAT_COLD:
                    begin
                        green = 1'b0;
                        red   = 1'b0;
                        blue  = 1'b1;
                    end
                    default:
                    begin
                        green = 1'b0;
                        blue  = 1'b0;
                        red   = ~red;
                    end
                endcase
            end
        endfunction

        function void advance_beep();
            if (tick_count < TICK_SAT)
                tick_count++;
            if (!alarm || muted)
                beep = 1'b0;
            else if (tick_count >= beep_ticks)
            begin
                tick_count = 4'd0;
                beep       = ~beep;
            end
        endfunction

        function void edit_step(logic up);
            int plant;
            case (position)
                LIM_PLANT:
                begin
                    plant = edit_lim[LIM_PLANT];
                    if (up && plant < PRESET_COUNT - 1)
                        load_edit(plant + 1);
                    else if (!up && plant > 0)
                        load_edit(plant - 1);
                end
                LIM_SOIL_LO, LIM_SOIL_HI:
                begin
                    if (up && edit_lim[position] <= SOIL_STEP_MAX)
                        edit_lim[position]++;
                    else if (!up && edit_lim[position] >= 7'd1)
                        edit_lim[position]--;
                end
                LIM_TEMP_LO:
                begin
                    if (up && edit_lim[LIM_TEMP_LO] < TEMP_LOW_MAX)
                        edit_lim[LIM_TEMP_LO]++;
                    else if (!up && edit_lim[LIM_TEMP_LO] > 7'd0)
                        edit_lim[LIM_TEMP_LO]--;
                end
                LIM_TEMP_HI:
                begin
                    if (up && edit_lim[LIM_TEMP_HI] < TEMP_HIGH_MAX)
                        edit_lim[LIM_TEMP_HI]++;
                    else if (!up && edit_lim[LIM_TEMP_HI] > TEMP_HIGH_MIN)
                        edit_lim[LIM_TEMP_HI]--;
                end
                default:
                    ;
            endcase
        endfunction

        function void apply_key(logic [2:0] key);
            if (mode == MODE_SETTINGS)
            begin
                case (key)
                    KEY1_SHORT: position = (position == LIM_TEMP_HI) ? LIM_PLANT : position + 3'd1;
                    KEY2:       edit_step(1'b0);
                    KEY3:       edit_step(1'b1);
                    KEY4:
                    begin
                        for (int n = 0; n < SETTING_ITEMS; n++)
                            active_lim[n] = edit_lim[n];
                        mode  = MODE_AUTO;
                        muted = 1'b0;
                    end
                    default:
                        ;
                endcase
            end
            else
            begin
                case (key)
                    KEY1_SHORT: mode = (mode == MODE_AUTO) ? MODE_MANUAL : MODE_AUTO;
                    KEY1_LONG:
                    begin
                        for (int n = 0; n < SETTING_ITEMS; n++)
                            edit_lim[n] = active_lim[n];
                        position = LIM_PLANT;
                        mode     = MODE_SETTINGS;
                    end
                    KEY2:
                        if (mode == MODE_MANUAL)
                            pump = ~pump;
                    KEY3:
                        if (mode == MODE_MANUAL)
                            fan = ~fan;
                    KEY4:
                    begin
                        muted = ~muted;
                        if (muted)
                            beep = 1'b0;
                    end
                    default:
                        ;
                endcase
            end
        endfunction

        function void note_request(in_item_t req);
            out_item_t res;
            if (req.operation == OP_TICK)
            begin
                if (mode == MODE_AUTO)
                    run_auto(req.soil_percent, int'($signed(req.temperature)),
                             req.temperature_valid);
                refresh_lamps();
                advance_beep();
            end
            else
                apply_key(req.key_code);

            res.pump_drive    = pump;
            res.fan_drive     = fan;
            res.led_red       = red;
            res.green_lamp    = green;
            res.blue_lamp     = blue;
            res.beeper        = beep;
            res.run_mode      = mode;
            res.plant_status  = status;
            res.alarm_flag    = alarm;
            res.mute_flag     = muted;
            res.edit_position = position;
            res.edit_value    = edit_lim[position];
            awaited.push_back(res);
        endfunction

        function void compare_field(string name, logic [6:0] want, logic [6:0] got,
                                    realtime stamp);
            if (want !== got)
            begin
                $display("%0.1f ns: %s expected %0d actual %0d", stamp, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(out_item_t got, realtime stamp);
            out_item_t want;
            if (awaited.size() == 0)
            begin
                $display("%0.1f ns: result %h with no request pending", stamp, got);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("pump_drive", want.pump_drive, got.pump_drive, stamp);
            compare_field("fan_drive", want.fan_drive, got.fan_drive, stamp);
            compare_field("led_red", want.led_red, got.led_red, stamp);
            compare_field("green_lamp", want.green_lamp, got.green_lamp, stamp);
            compare_field("blue_lamp", want.blue_lamp, got.blue_lamp, stamp);
            compare_field("beeper", want.beeper, got.beeper, stamp);
            compare_field("run_mode", want.run_mode, got.run_mode, stamp);
            compare_field("plant_status", want.plant_status, got.plant_status, stamp);
            compare_field("alarm_flag", want.alarm_flag, got.alarm_flag, stamp);
            compare_field("mute_flag", want.mute_flag, got.mute_flag, stamp);
            compare_field("edit_position", want.edit_position, got.edit_position, stamp);
            compare_field("edit_value", want.edit_value, got.edit_value, stamp);
        endfunction

    endclass

endpackage

### verif/irrigation_climate_controller_core_tb.sv
// Testbench of the irrigation climate controller core: directed and random sample
// ticks and key events with random idling, checked against icc_shadow_pkg.
// Depends on icc_pkg, icc_shadow_pkg and the core RTL.
module irrigation_climate_controller_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import icc_pkg::*;
    import icc_shadow_pkg::*;

    localparam int REQUEST_TARGET   = 1550;
    localparam int PHASES           = 6;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int SETTLE_CYCLES    = 6;
    localparam int TEMP_MIN         = -880;
    localparam int TEMP_MAX         = 2000;
    localparam int SOIL_MAX         = 100;
    localparam int KEY_UNUSED_FIRST = 5;
    localparam int KEY_UNUSED_LAST  = 7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_write = 1'b0;
    logic       cfg_index = CFG_FAN_HYST;
    logic [7:0] cfg_data  = 8'd0;

    icc_shadow  shadow;
    int         sent_items = 0;
    int         stall_hold = 0;
    logic       calm       = 1'b0;

    irrigation_climate_controller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                shadow.note_request(in_data);
            if (out_valid && !out_stall)
                shadow.check_result(out_data, $realtime);
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: random stalls, most short, a few long
    always @(negedge clk)
    begin
        if (stall_hold > 0)
            stall_hold--;
        else if (!calm && $urandom_range(0, 99) < 30)
        begin
            out_stall  <= 1'b1;
            stall_hold = idle_length();
        end
        else
            out_stall <= 1'b0;
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int random_temp();
        return int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
    endfunction

    function automatic in_item_t make_tick(int soil, int temp, logic valid);
        in_item_t r;
        r.operation         = OP_TICK;
        r.soil_percent      = soil[6:0];
        r.temperature       = temp[11:0];
        r.temperature_valid = valid;
        r.key_code          = 3'($urandom_range(0, 7));
        return r;
    endfunction

    function automatic in_item_t make_key(logic [2:0] key);
        in_item_t r;
        int       t;
        t = random_temp();
        r.operation         = OP_KEY;
        r.soil_percent      = 7'($urandom_range(0, SOIL_MAX));
        r.temperature       = t[11:0];
        r.temperature_valid = 1'($urandom_range(0, 1));
        r.key_code          = key;
        return r;
    endfunction

    function automatic in_item_t random_tick();
        return make_tick($urandom_range(0, SOIL_MAX), random_temp(), 1'($urandom_range(0, 1)));
    endfunction

    function automatic in_item_t unused_key();
        return make_key(3'($urandom_range(KEY_UNUSED_FIRST, KEY_UNUSED_LAST)));
    endfunction

    // Called at a falling edge; returns at a falling edge after the request is taken.
    task automatic send_request(input in_item_t req);
        int gap;
        in_data  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (req.operation == OP_TICK || req.key_code <= KEY4)
            sent_items++;
        gap = calm ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (shadow.awaited.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Ticks in auto mode around one operating point, so bands and alarms persist.
    task automatic auto_burst();
        int base_soil;
        int base_temp;
        int soil;
        int temp;
        int hi_raw;
        if (shadow.mode == MODE_SETTINGS)
            send_request(make_key(KEY4));
        if (shadow.mode == MODE_MANUAL)
            send_request(make_key(KEY1_SHORT));
        hi_raw = int'(shadow.active_lim[LIM_TEMP_HI]) * 16;
        case ($urandom_range(0, 3))
            0:       base_soil = $urandom_range(0, SOIL_MAX);
            1:       base_soil = shadow.active_lim[LIM_SOIL_LO];
            2:       base_soil = shadow.active_lim[LIM_SOIL_HI];
            default: base_soil = $urandom_range(0, 1) ? 0 : SOIL_MAX;
        endcase
        case ($urandom_range(0, 4))
            0:       base_temp = random_temp();
            1:       base_temp = hi_raw;
            2:       base_temp = hi_raw - int'(shadow.fan_hyst);
            3:       base_temp = int'(shadow.active_lim[LIM_TEMP_LO]) * 16;
            default: base_temp = $urandom_range(0, 1) ? TEMP_MIN : TEMP_MAX;
        endcase
        repeat ($urandom_range(3, 25))
        begin
            if ($urandom_range(0, 11) == 0)
                send_request(make_key(KEY4));
            else if ($urandom_range(0, 7) == 0)
                send_request(random_tick());
            else
            begin
                soil = clamp(base_soil + jitter(3), 0, SOIL_MAX);
                temp = clamp(base_temp + jitter(12), TEMP_MIN, TEMP_MAX);
                send_request(make_tick(soil, temp, $urandom_range(0, 9) != 0));
            end
        end
    endtask

    task automatic manual_session();
        int r;
        if (shadow.mode == MODE_SETTINGS)
            send_request(make_key(KEY4));
        if (shadow.mode == MODE_AUTO)
            send_request(make_key(KEY1_SHORT));
        repeat ($urandom_range(2, 12))
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_request(make_key(KEY2));
            else if (r < 55)
                send_request(make_key(KEY3));
            else if (r < 65)
                send_request(make_key(KEY4));
            else if (r < 95)
                send_request(random_tick());
            else
                send_request(unused_key());
        end
        if ($urandom_range(0, 4) != 0)
            send_request(make_key(KEY1_SHORT));
    endtask

    // Long runs of one step key drive the edited limits into their bounds.
    task automatic edit_session();
        int         r;
        int         run;
        logic [2:0] step_key;
        if (shadow.mode != MODE_SETTINGS)
            send_request(make_key(KEY1_LONG));
        repeat ($urandom_range(2, 16))
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                send_request(make_key(KEY1_SHORT));
            else if (r < 85)
            begin
                step_key = $urandom_range(0, 1) ? KEY3 : KEY2;
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
                repeat (run) send_request(make_key(step_key));
            end
            else if (r < 90)
                send_request(make_key(KEY1_LONG));
            else if (r < 95)
                send_request(random_tick());
            else
                send_request(unused_key());
        end
        if ($urandom_range(0, 6) != 0)
            send_request(make_key(KEY4));
    endtask

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int         phase;
        int         r;
        logic [7:0] hyst;
        logic [3:0] ticks;
        shadow = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, hysteresis edge, invalid reading, keys in every mode
        send_request(make_tick(0, TEMP_MIN, 1'b1));
        send_request(make_tick(SOIL_MAX, TEMP_MAX, 1'b1));
        send_request(make_tick(SOIL_MAX, 560, 1'b1));
        send_request(make_tick(SOIL_MAX, 528, 1'b1));
        send_request(make_tick(45, 100, 1'b0));
        send_request(make_tick(10, TEMP_MAX, 1'b1));
        send_request(make_key(KEY4));
        send_request(make_tick(10, TEMP_MAX, 1'b1));
        send_request(make_key(3'(KEY_UNUSED_FIRST)));
        send_request(make_key(3'(KEY_UNUSED_LAST)));
        send_request(make_key(KEY2));
        send_request(make_key(KEY3));
        send_request(make_key(KEY1_SHORT));
        send_request(make_key(KEY2));
        send_request(make_key(KEY3));
        send_request(make_tick(0, TEMP_MIN, 1'b1));
        send_request(make_key(KEY1_SHORT));
        send_request(make_key(KEY1_LONG));
        send_request(make_key(KEY1_LONG));
        send_request(make_key(KEY2));
        send_request(make_key(KEY2));
        send_request(make_key(KEY3));
        send_request(make_key(KEY3));
        send_request(make_key(KEY3));
        send_request(make_tick(50, 300, 1'b1));
        send_request(make_key(KEY1_SHORT));
        send_request(make_key(KEY4));

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_for_results();
                case (phase)
                    1:
                    begin
                        hyst  = 8'd0;
                        ticks = 4'd1;
                    end
                    2:
                    begin
                        hyst  = 8'd255;
                        ticks = 4'd15;
                    end
                    3:
                    begin
                        // zero toggle period behaves like one
                        hyst  = 8'($urandom_range(1, 254));
                        ticks = 4'd0;
                    end
                    4:
                    begin
                        hyst  = 8'($urandom_range(0, 255));
                        ticks = 4'($urandom_range(1, 15));
                    end
                    default:
                    begin
                        hyst  = 8'd32;
                        ticks = 4'd3;
                    end
                endcase
                cfg_write <= 1'b1;
                cfg_index <= CFG_FAN_HYST;
                cfg_data  <= hyst;
                @(negedge clk);
                cfg_index <= CFG_BEEP_TICKS;
                cfg_data  <= {4'd0, ticks};
                @(negedge clk);
                cfg_write <= 1'b0;
                shadow.fan_hyst   = hyst;
                shadow.beep_ticks = ticks;
            end
            while (sent_items < (REQUEST_TARGET * (phase + 1)) / PHASES)
            begin
                calm = ($urandom_range(0, 6) == 0);
                r = $urandom_range(0, 99);
                if (r < 40)
                    auto_burst();
                else if (r < 60)
                    manual_session();
                else if (r < 85)
                    edit_session();
                else
                begin
                    repeat ($urandom_range(1, 5))
                    begin
                        if ($urandom_range(0, 1))
                            send_request(make_key(3'($urandom_range(0, 7))));
                        else
                            send_request(random_tick());
                    end
                end
            end
        end

        calm = 1'b0;
        wait_for_results();
        if (shadow.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
